### hw/rtl/ray_box_slab_intersect_2d_macros.svh
// Assertion macros for the ray/box slab intersect block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef RAY_BOX_SLAB_INTERSECT_2D_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_2D_MACROS_SVH

// property that must hold at every edge out of reset
`define RBS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rbs assertion failed");

// a at one edge implies b at the next
`define RBS_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("rbs sequencing assertion failed");

`endif

### hw/rtl/rbs_pkg.sv
// Shared types, constants and helpers for the ray/box slab intersect block.
// No dependencies.
package rbs_pkg;

    localparam int DIV_BITS   = 48;                    // quotient bits, Q16.16 shifted numerator
    localparam int DIV_STEP   = 4;                     // quotient bits per divider stage
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;
    localparam int DIV_LAT    = DIV_STAGES + 2;        // input reg + stages + saturation reg

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 32;

    localparam logic [1:0] CFG_MIN_X = 2'd0;
    localparam logic [1:0] CFG_MIN_Y = 2'd1;
    localparam logic [1:0] CFG_MAX_X = 2'd2;
    localparam logic [1:0] CFG_MAX_Y = 2'd3;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] near_limit;
        logic signed [31:0] far_limit;
    } in_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] entry_distance;
    } out_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
    } box_t;

    // classified ray, handed from front to back
    typedef struct packed {
        logic [31:0]        mag_min_x;
        logic [31:0]        mag_max_x;
        logic [31:0]        mag_min_y;
        logic [31:0]        mag_max_y;
        logic               neg_min_x;
        logic               neg_max_x;
        logic               neg_min_y;
        logic               neg_max_y;
        logic [31:0]        den_x;
        logic [31:0]        den_y;
        logic               par_x;
        logic               pok_x;
        logic               par_y;
        logic               pok_y;
        logic signed [31:0] near_limit;
        logic signed [31:0] far_limit;
    } mid_t;

    // magnitude of a 33-bit signed value; fits 32 bits unsigned for any v above -2**32
    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

endpackage

### hw/rtl/rbs_front.sv
// Front end: forms slab differences, magnitudes, signs and parallel-slab checks.
// Depends on rbs_pkg.
module rbs_front
    import rbs_pkg::*;
(
    input  in_t  request,
    input  box_t box,
    output mid_t mid
);

    logic signed [32:0] d_min_x;
    logic signed [32:0] d_max_x;
    logic signed [32:0] d_min_y;
    logic signed [32:0] d_max_y;

    always_comb
    begin
        d_min_x = {box.min_x[31], box.min_x} - {request.origin_x[31], request.origin_x};
        d_max_x = {box.max_x[31], box.max_x} - {request.origin_x[31], request.origin_x};
        d_min_y = {box.min_y[31], box.min_y} - {request.origin_y[31], request.origin_y};
        d_max_y = {box.max_y[31], box.max_y} - {request.origin_y[31], request.origin_y};

        mid.mag_min_x = mag33(d_min_x);
        mid.mag_max_x = mag33(d_max_x);
        mid.mag_min_y = mag33(d_min_y);
        mid.mag_max_y = mag33(d_max_y);
        // quotient sign, truncation toward zero comes from dividing magnitudes
        mid.neg_min_x = d_min_x[32] ^ request.dir_x[31];
        mid.neg_max_x = d_max_x[32] ^ request.dir_x[31];
        mid.neg_min_y = d_min_y[32] ^ request.dir_y[31];
        mid.neg_max_y = d_max_y[32] ^ request.dir_y[31];
        mid.den_x     = mag33({request.dir_x[31], request.dir_x});
        mid.den_y     = mag33({request.dir_y[31], request.dir_y});

        mid.par_x = (request.dir_x == '0);
        mid.par_y = (request.dir_y == '0);
        mid.pok_x = !(request.origin_x < box.min_x || request.origin_x > box.max_x);
        mid.pok_y = !(request.origin_y < box.min_y || request.origin_y > box.max_y);

        mid.near_limit = request.near_limit;
        mid.far_limit  = request.far_limit;
    end

endmodule

### hw/rtl/rbs_fifo.sv
// Small register-based FIFO, used between front and back and at the result side.
// Depends on rbs_pkg for the default depth MID_DEPTH_DEF.
module rbs_fifo
    import rbs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = MID_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             wr_en;
    logic             rd_en;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/rbs_div.sv
// Pipelined restoring divider: (mag << 16) / den, sign applied, saturated to Q16.16.
// One division per cycle. Depends on rbs_pkg.
module rbs_div
    import rbs_pkg::*;
(
    input  logic               clk,
    input  logic [31:0]        num_mag,
    input  logic [31:0]        den,
    input  logic               neg,
    output logic signed [31:0] quo
);

    // sh holds remaining numerator bits on top, quotient bits shift in at the bottom
    typedef struct packed {
        logic [31:0]         rem;
        logic [DIV_BITS-1:0] sh;
        logic [31:0]         den;
        logic                neg;
    } div_stage_t;

    div_stage_t         st_reg  [0:DIV_STAGES];
    div_stage_t         st_next [1:DIV_STAGES];
    logic signed [31:0] quo_reg, quo_next;

    always_comb
    begin
        logic [31:0]         rem;
        logic [DIV_BITS-1:0] sh;
        logic [32:0]         trial;
        logic [32:0]         diff;
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            rem = st_reg[k-1].rem;
            sh  = st_reg[k-1].sh;
            for (int j = 0; j < DIV_STEP; j++)
            begin
                trial = {rem, sh[DIV_BITS-1]};
                sh    = {sh[DIV_BITS-2:0], 1'b0};
                diff  = trial - {1'b0, st_reg[k-1].den};
                if (trial >= {1'b0, st_reg[k-1].den})
                begin
                    rem   = diff[31:0];
                    sh[0] = 1'b1;
                end
                else
                begin
                    rem = trial[31:0];
                end
            end
            st_next[k].rem = rem;
            st_next[k].sh  = sh;
            st_next[k].den = st_reg[k-1].den;
            st_next[k].neg = st_reg[k-1].neg;
        end
    end

    always_comb
    begin
        logic [DIV_BITS-1:0] mag;
        logic                over_pos;
        logic                over_neg;
        mag      = st_reg[DIV_STAGES].sh;
        over_pos = |mag[DIV_BITS-1:31];
        over_neg = (|mag[DIV_BITS-1:32]) || (mag[31] && (|mag[30:0]));
        if (st_reg[DIV_STAGES].neg)
        begin
            quo_next = over_neg ? Q_MIN : -$signed(mag[31:0]);
        end
        else
        begin
            quo_next = over_pos ? Q_MAX : $signed(mag[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg[0].rem <= '0;
        st_reg[0].sh  <= {num_mag, 16'd0};
        st_reg[0].den <= den;
        st_reg[0].neg <= neg;
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            st_reg[k] <= st_next[k];
        end
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

### hw/rtl/rbs_back.sv
// Back end: four slab dividers, interval ordering, overlap and window tests.
// Free-running pipeline: the dividers, then the ordering, overlap and window registers. Depends on rbs_pkg, rbs_div.
module rbs_back
    import rbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  mid_t in_item,
    output logic out_valid,
    output out_t out_item
);

    typedef struct packed {
        logic               par_x;
        logic               pok_x;
        logic               par_y;
        logic               pok_y;
        logic signed [31:0] near_limit;
        logic signed [31:0] far_limit;
    } side_t;

    side_t              side_reg [0:DIV_LAT-1];
    logic [DIV_LAT-1:0] vld_reg;

    logic signed [31:0] q_min_x, q_max_x, q_min_y, q_max_y;

    logic               c1_vld_reg, c2_vld_reg, out_vld_reg;
    logic signed [31:0] xin_reg, xout_reg, yin_reg, yout_reg;
    logic signed [31:0] xin_next, xout_next, yin_next, yout_next;
    logic               c1_ok_reg, c1_ok_next;
    logic signed [31:0] c1_near_reg, c1_far_reg;
    logic               c2_ok_reg, c2_ok_next;
    logic signed [31:0] tin_reg, tout_reg, tin_next, tout_next;
    logic signed [31:0] c2_near_reg, c2_far_reg;
    out_t               out_reg, out_next;
    side_t              s_last;

    rbs_div u_div_min_x (.clk(clk), .num_mag(in_item.mag_min_x), .den(in_item.den_x),
                         .neg(in_item.neg_min_x), .quo(q_min_x));
    rbs_div u_div_max_x (.clk(clk), .num_mag(in_item.mag_max_x), .den(in_item.den_x),
                         .neg(in_item.neg_max_x), .quo(q_max_x));
    rbs_div u_div_min_y (.clk(clk), .num_mag(in_item.mag_min_y), .den(in_item.den_y),
                         .neg(in_item.neg_min_y), .quo(q_min_y));
    rbs_div u_div_max_y (.clk(clk), .num_mag(in_item.mag_max_y), .den(in_item.den_y),
                         .neg(in_item.neg_max_y), .quo(q_max_y));

    assign s_last = side_reg[DIV_LAT-1];

    always_comb
    begin
        xin_next  = (q_min_x > q_max_x) ? q_max_x : q_min_x;
        xout_next = (q_min_x > q_max_x) ? q_min_x : q_max_x;
        yin_next  = (q_min_y > q_max_y) ? q_max_y : q_min_y;
        yout_next = (q_min_y > q_max_y) ? q_min_y : q_max_y;
        if (s_last.par_x)
        begin
            xin_next  = Q_MIN;
            xout_next = Q_MAX;
        end
        if (s_last.par_y)
        begin
            yin_next  = Q_MIN;
            yout_next = Q_MAX;
        end
        c1_ok_next = (!s_last.par_x || s_last.pok_x) && (!s_last.par_y || s_last.pok_y);

        c2_ok_next = c1_ok_reg && !(xin_reg > yout_reg || yin_reg > xout_reg);
        tin_next   = (yin_reg > xin_reg) ? yin_reg : xin_reg;
        tout_next  = (yout_reg < xout_reg) ? yout_reg : xout_reg;

        out_next.hit            = c2_ok_reg && !(tin_reg > c2_far_reg || tout_reg < c2_near_reg);
        out_next.entry_distance = out_next.hit ? tin_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            c1_vld_reg  <= 1'b0;
            c2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= {vld_reg[DIV_LAT-2:0], in_valid};
            c1_vld_reg  <= vld_reg[DIV_LAT-1];
            c2_vld_reg  <= c1_vld_reg;
            out_vld_reg <= c2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0].par_x      <= in_item.par_x;
        side_reg[0].pok_x      <= in_item.pok_x;
        side_reg[0].par_y      <= in_item.par_y;
        side_reg[0].pok_y      <= in_item.pok_y;
        side_reg[0].near_limit <= in_item.near_limit;
        side_reg[0].far_limit  <= in_item.far_limit;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
        xin_reg     <= xin_next;
        xout_reg    <= xout_next;
        yin_reg     <= yin_next;
        yout_reg    <= yout_next;
        c1_ok_reg   <= c1_ok_next;
        c1_near_reg <= s_last.near_limit;
        c1_far_reg  <= s_last.far_limit;
        c2_ok_reg   <= c2_ok_next;
        tin_reg     <= tin_next;
        tout_reg    <= tout_next;
        c2_near_reg <= c1_near_reg;
        c2_far_reg  <= c1_far_reg;
        out_reg     <= out_next;
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

endmodule

### hw/rtl/ray_box_slab_intersect_2d.sv
// Top level of the 2D ray/axis-aligned box slab intersect block.
// Depends on rbs_pkg, rbs_front, rbs_fifo, rbs_back and the macros header.
//
// Usage:
//   Request side is a queue: a beat is taken at a clock edge with push high and
//   full low. Result side is a queue: the oldest result sits on result while
//   empty is low and is taken at an edge with pop high.
//   Config: cfg_valid/cfg_index/cfg_data write box_min_x, box_min_y, box_max_x,
//   box_max_y (index 0..3); cfg_ready is always high.
// Timing:
//   One ray per cycle sustained while results are popped. A ray goes through the
//   request queue, then a back pipeline set by the four dividers of 48 quotient
//   bits (4 quotient bits per stage) and the ordering, overlap and window
//   registers; its result then enters the result queue and can be popped there.
//   Issue into the back pipeline is gated by a credit count covering beats in
//   flight plus those in the result queue, so a stalled receiver fills the
//   result queue, then the request queue, then raises full. Nothing is dropped.
// Reset:
//   Queues empty, credits zero, box registers zero.
`include "ray_box_slab_intersect_2d_macros.svh"

module ray_box_slab_intersect_2d
    import rbs_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_t         request,
    output logic        empty,
    input  logic        pop,
    output out_t        result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CW = $clog2(OUT_DEPTH + 1);

    box_t  box_reg;
    mid_t  front_mid;
    logic  [$bits(mid_t)-1:0] mid_rdata;
    logic  mid_empty;
    logic  issue;
    logic  back_valid;
    out_t  back_item;
    logic  [$bits(out_t)-1:0] out_rdata;
    logic  out_full;
    logic  out_push;
    logic  pop_fire;
    logic  [CW-1:0] credit_reg, credit_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_X: box_reg.min_x <= cfg_data;
                CFG_MIN_Y: box_reg.min_y <= cfg_data;
                CFG_MAX_X: box_reg.max_x <= cfg_data;
                CFG_MAX_Y: box_reg.max_y <= cfg_data;
                default:   box_reg <= box_reg;
            endcase
        end
    end

    rbs_front u_front (
        .request(request),
        .box    (box_reg),
        .mid    (front_mid)
    );

    rbs_fifo #(.WIDTH($bits(mid_t)), .DEPTH(MID_DEPTH)) u_mid_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata(front_mid),
        .pop  (issue),
        .rdata(mid_rdata),
        .full (full),
        .empty(mid_empty)
    );

    // credit covers the back pipeline plus the result queue
    assign issue    = !mid_empty && (credit_reg < CW'(OUT_DEPTH));
    assign pop_fire = pop && !empty;

    always_comb
    begin
        credit_next = credit_reg;
        if (issue && !pop_fire)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (pop_fire && !issue)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    rbs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (issue),
        .in_item  (mid_t'(mid_rdata)),
        .out_valid(back_valid),
        .out_item (back_item)
    );

    assign out_push = back_valid;

    rbs_fifo #(.WIDTH($bits(out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (out_push),
        .wdata(back_item),
        .pop  (pop),
        .rdata(out_rdata),
        .full (out_full),
        .empty(empty)
    );

    assign result = out_t'(out_rdata);

    `RBS_ASSERT(a_credit_bound, credit_reg <= CW'(OUT_DEPTH))
    `RBS_ASSERT(a_out_room, out_push |-> !out_full)
    `RBS_ASSERT(a_miss_zero, (!empty && !result.hit) |-> (result.entry_distance == '0))
    `RBS_ASSERT_NEXT(a_credit_step, issue && !pop_fire, credit_reg == $past(credit_reg) + 1'b1)

endmodule
